// ----- sv/control_panel_input_conditioner_defines.svh -----
// ----------------------------------------------------------------------------
// control panel input conditioner assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef CONTROL_PANEL_INPUT_CONDITIONER_DEFINES_SVH
`define CONTROL_PANEL_INPUT_CONDITIONER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CPIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpic assertion failed");

// consequent must hold in the cycle after the antecedent
`define CPIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpic assertion failed");

`endif

// ----- sv/cpic_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpic_pkg
// types, constants and the brightness table builder for the panel conditioner
// ----------------------------------------------------------------------------
package cpic_pkg;

    // field widths
    localparam int POT_W       = 10;
    localparam int COUNT_W     = 32;
    localparam int BRIGHT_W    = 8;
    localparam int POT_MAX     = 1023;
    localparam int MAG_W       = 2 * POT_W;

    // averaging depth default
    localparam int DEF_AVG_SAMPLES = 3;

    // sine periods across the pot travel
    localparam int BRIGHT_CYCLES = 3;

    // reset values
    localparam logic [COUNT_W-1:0] RESET_LAST_COUNT = COUNT_W'(-999);
    localparam logic [POT_W-1:0]   RESET_SCALE_LOW  = POT_W'(201);
    localparam logic [POT_W-1:0]   RESET_SCALE_HIGH = POT_W'(300);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_POT_SCALE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POT_SCALE_HIGH = 1'b1;

    // exact divide by 1023 through a reciprocal, valid for products below 2^20
    localparam int DIV_SH      = 30;
    localparam int DIV_RECIP_W = 21;
    localparam longint unsigned DIV_RECIP_FULL =
        ((64'd1 << DIV_SH) + POT_MAX - 1) / POT_MAX;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'(DIV_RECIP_FULL);

    // fixed-point constants for the sine table
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // switch positions
    typedef enum logic [1:0] {
        SW_CENTRE  = 2'd0,
        SW_PIN_ONE = 2'd1,
        SW_PIN_TWO = 2'd2
    } sw_pos_t;

    // input beat, first field in the highest bits
    typedef struct packed {
        logic [POT_W-1:0]          zoom_pot;
        logic [POT_W-1:0]          led_pot;
        logic                      right_button_level;
        logic                      left_button_level;
        logic signed [COUNT_W-1:0] right_count;
        logic signed [COUNT_W-1:0] left_count;
        logic                      switch_b_pin_two;
        logic                      switch_b_pin_one;
        logic                      switch_a_pin_two;
        logic                      switch_a_pin_one;
    } in_beat_t;

    // result beat, first field in the highest bits
    typedef struct packed {
        logic [BRIGHT_W-1:0]       led_brightness;
        logic [POT_W-1:0]          zoom_value;
        logic [POT_W-1:0]          led_pot_scaled;
        logic                      right_pressed;
        logic                      left_pressed;
        logic signed [COUNT_W-1:0] right_press_turn;
        logic signed [COUNT_W-1:0] left_press_turn;
        logic signed [COUNT_W-1:0] right_turn;
        logic signed [COUNT_W-1:0] left_turn;
        sw_pos_t                   switch_b_position;
        sw_pos_t                   switch_a_position;
    } out_beat_t;

    // fields that ride along the pipe while the pot scaling is worked out
    typedef struct packed {
        logic [BRIGHT_W-1:0]       led_brightness;
        logic [POT_W-1:0]          zoom_value;
        logic                      right_pressed;
        logic                      left_pressed;
        logic signed [COUNT_W-1:0] right_press_turn;
        logic signed [COUNT_W-1:0] left_press_turn;
        logic signed [COUNT_W-1:0] right_turn;
        logic signed [COUNT_W-1:0] left_turn;
        sw_pos_t                   switch_b_position;
        sw_pos_t                   switch_a_position;
    } pass_t;

    localparam int IN_W        = $bits(in_beat_t);
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = $bits(out_beat_t);
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef logic [BRIGHT_W-1:0] bright_rom_t [POT_MAX+1];

    // three-position switch from its pin pair, low pin means grounded
    function automatic sw_pos_t decode_switch(input logic pin_one, input logic pin_two);
        sw_pos_t pos;
        if (!pin_one && pin_two)
            pos = SW_PIN_ONE;
        else if (pin_one && !pin_two)
            pos = SW_PIN_TWO;
        else
            pos = SW_CENTRE;
        return pos;
    endfunction

    // one brightness entry: quarter-wave fold, Horner sine in Q30, offset and scale
    function automatic logic [BRIGHT_W-1:0] bright_of(input logic [POT_W-1:0] pot);
        longint unsigned m;
        longint unsigned a;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned r;
        longint unsigned s;
        longint unsigned v;
        longint unsigned b;
        logic            neg;
        m   = (64'(BRIGHT_CYCLES) * 64'(pot)) % POT_MAX;
        a   = 64'd4 * m;
        neg = 1'b0;
        if (a > 64'd2046)
        begin
            a   = 64'd4092 - a;
            neg = 1'b1;
        end
        if (a > 64'd1023)
            a = 64'd2046 - a;
        x  = (a * HALF_PI_Q30) / POT_MAX;
        x2 = (x * x) >> 30;
        r  = Q30_ONE;
        r  = Q30_ONE - ((x2 * r) >> 30) / 156;
        r  = Q30_ONE - ((x2 * r) >> 30) / 110;
        r  = Q30_ONE - ((x2 * r) >> 30) / 72;
        r  = Q30_ONE - ((x2 * r) >> 30) / 42;
        r  = Q30_ONE - ((x2 * r) >> 30) / 20;
        r  = Q30_ONE - ((x2 * r) >> 30) / 6;
        s  = (x * r) >> 30;
        if (s > Q30_ONE)
            s = Q30_ONE;
        v = neg ? (Q30_ONE - s) : (Q30_ONE + s);
        b = (v * 64'd255) >> 31;
        if (b > 64'd255)
            b = 64'd255;
        return BRIGHT_W'(b);
    endfunction

    // whole brightness table, worked out at elaboration
    function automatic bright_rom_t build_bright_rom();
        bright_rom_t rom;
        for (int i = 0; i <= POT_MAX; i++)
            rom[i] = bright_of(POT_W'(i));
        return rom;
    endfunction

endpackage

// ----- sv/control_panel_input_conditioner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control panel input conditioner
// conditions one panel scan a beat: switch decode, knob deltas, averaged and
// scaled LED pot, zoom pass-through and a sine brightness
// ----------------------------------------------------------------------------
//
//  port group   dir   beat contents
//  s_axis_*     in    one panel scan (in_beat_t)
//  m_axis_*     out   one conditioned result (out_beat_t)
//  cfg_*        in    scale register writes, index 0 low, 1 high
//
//  one scan accepted per cycle unless a stalled output has filled the pipe; the
//  result passes through stages s1, s2 and s3 into the output register
//  the pipe is set by the pot path: divide-by-depth, span multiply and
//  divide-by-1023, each a multiplier with its own register stage
//  knob and pot-history state update at acceptance, the brightness table is read then
//  a full stage holds only while its successor holds, so bubbles close up
//  rst_n resets knob state, pot history, scale registers and stage valids
//
module control_panel_input_conditioner
    import cpic_pkg::*;
#(
    parameter int AVG_SAMPLES = DEF_AVG_SAMPLES
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // switch_a_pin_one, switch_a_pin_two, switch_b_pin_one, switch_b_pin_two,
    // left_count, right_count, left_button_level, right_button_level,
    // led_pot, zoom_pot
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,

    // switch_a_position, switch_b_position, left_turn, right_turn,
    // left_press_turn, right_press_turn, left_pressed, right_pressed,
    // led_pot_scaled, zoom_value, led_brightness
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [POT_W-1:0]       cfg_wdata
);

    localparam int SUM_W       = $clog2(AVG_SAMPLES * POT_MAX + 1);
    localparam int SLOT_W      = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
    localparam int AVG_SH      = SUM_W + 4;
    localparam int AVG_RECIP_W = AVG_SH + 1;
    localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;
    localparam int DIV_PROD_W  = MAG_W + DIV_RECIP_W;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'(((64'd1 << AVG_SH) + AVG_SAMPLES - 1) / AVG_SAMPLES);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVG_SAMPLES - 1);
    localparam bright_rom_t BRIGHT_ROM = build_bright_rom();

    // configuration
    logic [POT_W-1:0]   pot_scale_low_reg;
    logic [POT_W-1:0]   pot_scale_high_reg;

    // knob state
    logic [COUNT_W-1:0] last_left_count_reg;
    logic [COUNT_W-1:0] last_right_count_reg;
    logic [COUNT_W-1:0] left_press_base_reg;
    logic [COUNT_W-1:0] right_press_base_reg;
    logic               left_press_valid_reg;
    logic               right_press_valid_reg;

    // pot history
    logic [POT_W-1:0]   pot_history_reg [AVG_SAMPLES];
    logic [SUM_W-1:0]   pot_sum_reg;
    logic [SUM_W-1:0]   pot_sum_next;
    logic [SLOT_W-1:0]  history_slot_reg;
    logic [SLOT_W-1:0]  history_slot_next;

    // pipe stages
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               s3_valid_reg;
    logic               out_valid_reg;
    pass_t              s1_pass_reg;
    pass_t              s1_pass_next;
    pass_t              s2_pass_reg;
    pass_t              s3_pass_reg;
    logic [SUM_W-1:0]   s1_sum_reg;
    logic [POT_W-1:0]   s2_avg_reg;
    logic [POT_W-1:0]   s2_avg_next;
    logic [MAG_W-1:0]   s3_mag_reg;
    logic [MAG_W-1:0]   s3_mag_next;
    logic               s3_neg_reg;
    logic               s3_neg_next;
    out_beat_t          out_reg;
    out_beat_t          out_next;

    logic               en1;
    logic               en2;
    logic               en3;
    logic               en4;
    logic               in_accept;
    in_beat_t           in_beat;
    logic               left_press;
    logic               right_press;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [POT_W-1:0]   span_mag;
    logic [DIV_PROD_W-1:0] div_prod;
    logic [POT_W-1:0]   quot;

    // stage enables, a stage moves when empty or when its successor moves
    assign en4           = !out_valid_reg || m_axis_tready;
    assign en3           = !s3_valid_reg || en4;
    assign en2           = !s2_valid_reg || en3;
    assign en1           = !s1_valid_reg || en2;
    assign s_axis_tready = en1;
    assign in_accept     = s_axis_tvalid && en1;

    assign in_beat       = in_beat_t'(s_axis_tdata[IN_W-1:0]);
    assign left_press    = !in_beat.left_button_level;
    assign right_press   = !in_beat.right_button_level;

    // knob deltas, switch decode, brightness and pass-through fields of the new beat
    always_comb
    begin
        s1_pass_next = '0;
        s1_pass_next.switch_a_position = decode_switch(in_beat.switch_a_pin_one,
                                                       in_beat.switch_a_pin_two);
        s1_pass_next.switch_b_position = decode_switch(in_beat.switch_b_pin_one,
                                                       in_beat.switch_b_pin_two);
        s1_pass_next.left_turn  = left_press ? '0 : in_beat.left_count - last_left_count_reg;
        s1_pass_next.right_turn = right_press ? '0
                                              : in_beat.right_count - last_right_count_reg;
        s1_pass_next.left_press_turn  = (left_press && left_press_valid_reg)
                                        ? in_beat.left_count - left_press_base_reg : '0;
        s1_pass_next.right_press_turn = (right_press && right_press_valid_reg)
                                        ? in_beat.right_count - right_press_base_reg : '0;
        s1_pass_next.left_pressed   = left_press;
        s1_pass_next.right_pressed  = right_press;
        s1_pass_next.zoom_value     = in_beat.zoom_pot;
        s1_pass_next.led_brightness = BRIGHT_ROM[in_beat.led_pot];
    end

    // running sum over the history ring
    assign pot_sum_next      = pot_sum_reg - SUM_W'(pot_history_reg[history_slot_reg])
                               + SUM_W'(in_beat.led_pot);
    assign history_slot_next = (history_slot_reg == LAST_SLOT) ? '0
                                                              : history_slot_reg + 1'b1;

    // average by reciprocal multiply
    assign avg_prod    = AVG_PROD_W'(s1_sum_reg) * AVG_PROD_W'(AVG_RECIP);
    assign s2_avg_next = avg_prod[AVG_SH +: POT_W];

    // span magnitude and direction times the average
    assign s3_neg_next = pot_scale_high_reg < pot_scale_low_reg;
    assign span_mag    = s3_neg_next ? pot_scale_low_reg - pot_scale_high_reg
                                     : pot_scale_high_reg - pot_scale_low_reg;
    assign s3_mag_next = MAG_W'(s2_avg_reg) * MAG_W'(span_mag);

    // divide by 1023 toward zero, then offset by the low register
    assign div_prod = DIV_PROD_W'(s3_mag_reg) * DIV_PROD_W'(DIV_RECIP);
    assign quot     = div_prod[DIV_SH +: POT_W];

    always_comb
    begin
        out_next = '0;
        out_next.switch_a_position = s3_pass_reg.switch_a_position;
        out_next.switch_b_position = s3_pass_reg.switch_b_position;
        out_next.left_turn         = s3_pass_reg.left_turn;
        out_next.right_turn        = s3_pass_reg.right_turn;
        out_next.left_press_turn   = s3_pass_reg.left_press_turn;
        out_next.right_press_turn  = s3_pass_reg.right_press_turn;
        out_next.left_pressed      = s3_pass_reg.left_pressed;
        out_next.right_pressed     = s3_pass_reg.right_pressed;
        out_next.led_pot_scaled    = s3_neg_reg ? pot_scale_low_reg - quot
                                                : pot_scale_low_reg + quot;
        out_next.zoom_value        = s3_pass_reg.zoom_value;
        out_next.led_brightness    = s3_pass_reg.led_brightness;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pot_scale_low_reg  <= RESET_SCALE_LOW;
            pot_scale_high_reg <= RESET_SCALE_HIGH;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_POT_SCALE_LOW:  pot_scale_low_reg  <= cfg_wdata;
                REG_POT_SCALE_HIGH: pot_scale_high_reg <= cfg_wdata;
                default:            pot_scale_low_reg  <= pot_scale_low_reg;
            endcase
        end
    end

    // scan state, updated once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_count_reg   <= RESET_LAST_COUNT;
            last_right_count_reg  <= RESET_LAST_COUNT;
            left_press_base_reg   <= '0;
            right_press_base_reg  <= '0;
            left_press_valid_reg  <= 1'b0;
            right_press_valid_reg <= 1'b0;
            pot_sum_reg           <= '0;
            history_slot_reg      <= '0;
            for (int i = 0; i < AVG_SAMPLES; i++)
                pot_history_reg[i] <= '0;
        end
        else if (in_accept)
        begin
            last_left_count_reg   <= in_beat.left_count;
            last_right_count_reg  <= in_beat.right_count;
            left_press_base_reg   <= left_press ? in_beat.left_count : '0;
            right_press_base_reg  <= right_press ? in_beat.right_count : '0;
            left_press_valid_reg  <= left_press;
            right_press_valid_reg <= right_press;
            pot_sum_reg           <= pot_sum_next;
            history_slot_reg      <= history_slot_next;
            pot_history_reg[history_slot_reg] <= in_beat.led_pot;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= s_axis_tvalid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // stage payloads, brightness table read registered with the beat
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pass_reg <= s1_pass_next;
            s1_sum_reg  <= pot_sum_next;
        end
        if (en2)
        begin
            s2_pass_reg <= s1_pass_reg;
            s2_avg_reg  <= s2_avg_next;
        end
        if (en3)
        begin
            s3_pass_reg <= s2_pass_reg;
            s3_mag_reg  <= s3_mag_next;
            s3_neg_reg  <= s3_neg_next;
        end
        if (en4)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_reg);

endmodule

// ----- sv/cpic_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpic_checker
// port-level checks on the panel conditioner, bound to the top level
// ----------------------------------------------------------------------------
`include "control_panel_input_conditioner_defines.svh"

module cpic_checker
    import cpic_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready
);

    out_beat_t res;
    logic      out_stall;
    logic      any_pressed;
    logic      pressed_quiet;
    logic      any_released;
    logic      released_quiet;

    assign res       = out_beat_t'(m_axis_tdata[OUT_W-1:0]);
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // per-knob views of the result beat
    assign any_pressed    = m_axis_tvalid && (res.left_pressed || res.right_pressed);
    assign pressed_quiet  = (!res.left_pressed || res.left_turn == '0)
                            && (!res.right_pressed || res.right_turn == '0);
    assign any_released   = m_axis_tvalid && (!res.left_pressed || !res.right_pressed);
    assign released_quiet = (res.left_pressed || res.left_press_turn == '0)
                            && (res.right_pressed || res.right_press_turn == '0);

    // a stalled result beat stays put
    `CPIC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // a held knob sends its motion to the pressed delta only
    `CPIC_ASSERT_SAME(a_press_no_turn, clk, rst_n, any_pressed, pressed_quiet)

    // a released knob has no pressed delta
    `CPIC_ASSERT_SAME(a_release_no_pturn, clk, rst_n, any_released, released_quiet)

    // with nothing waiting at the output the pipe always takes a beat
    `CPIC_ASSERT_SAME(a_ready_when_drained, clk, rst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind control_panel_input_conditioner cpic_checker u_cpic_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
